// ===== sv/touchdown_joint_slew_limiter_macros.svh =====
// assertion macros for the touchdown joint slew limiter
// expects clk_i and rst_ni in the scope that uses them
`ifndef TOUCHDOWN_JOINT_SLEW_LIMITER_MACROS_SVH
`define TOUCHDOWN_JOINT_SLEW_LIMITER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define TDJSL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdjsl assertion failed");

// antecedent implies consequent in the next cycle
`define TDJSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdjsl assertion failed");

`else

`define TDJSL_ASSERT_SAME(label, ante, cons)
`define TDJSL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/tdjsl_pkg.sv =====
// types and constants shared by the touchdown joint slew limiter
// no dependencies
package tdjsl_pkg;

  localparam int ANGLE_W    = 16;
  localparam int RATE_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int SLEW_W     = 8;
  localparam int LEG_W      = 2;
  localparam int JOINTS_MAX = 3;

  // apb register file
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RATE    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLEW_FRAMES = 2'd2;

  localparam logic [LIMIT_W-1:0] MAX_STEP_RST    = 15'd164;
  localparam logic [LIMIT_W-1:0] MAX_RATE_RST    = 15'd4096;
  localparam logic [SLEW_W-1:0]  SLEW_FRAMES_RST = 8'd8;

  typedef struct packed {
    logic [LEG_W-1:0]         leg;
    logic                     limiter_on;
    logic                     contact;
    logic signed [ANGLE_W-1:0] pos_in_0;
    logic signed [ANGLE_W-1:0] pos_in_1;
    logic signed [ANGLE_W-1:0] pos_in_2;
    logic signed [RATE_W-1:0]  rate_in_0;
    logic signed [RATE_W-1:0]  rate_in_1;
    logic signed [RATE_W-1:0]  rate_in_2;
  } in_item_t;

  typedef struct packed {
    logic [LEG_W-1:0]         leg_out;
    logic signed [ANGLE_W-1:0] pos_out_0;
    logic signed [ANGLE_W-1:0] pos_out_1;
    logic signed [ANGLE_W-1:0] pos_out_2;
    logic signed [RATE_W-1:0]  rate_out_0;
    logic signed [RATE_W-1:0]  rate_out_1;
    logic signed [RATE_W-1:0]  rate_out_2;
    logic                     limiting;
  } out_item_t;

  // per-frame decision from the leg state to the lanes
  typedef struct packed {
    logic leg_ok;
    logic limit;
  } ctl_t;

endpackage

// ===== sv/tdjsl_lane.sv =====
// one joint lane: clamps the angle step and the rate
// depends on tdjsl_pkg
module tdjsl_lane (
  input  logic                                  clamp_en_i,
  input  logic signed [tdjsl_pkg::ANGLE_W-1:0]  pos_i,
  input  logic signed [tdjsl_pkg::RATE_W-1:0]   rate_i,
  input  logic signed [tdjsl_pkg::ANGLE_W-1:0]  last_i,
  input  logic [tdjsl_pkg::LIMIT_W-1:0]         max_step_i,
  input  logic [tdjsl_pkg::LIMIT_W-1:0]         max_rate_i,
  output logic signed [tdjsl_pkg::ANGLE_W-1:0]  pos_o,
  output logic signed [tdjsl_pkg::RATE_W-1:0]   rate_o
);

  localparam int AW = tdjsl_pkg::ANGLE_W;
  localparam int RW = tdjsl_pkg::RATE_W;
  localparam int LW = tdjsl_pkg::LIMIT_W;

  logic signed [AW:0] diff;
  logic signed [AW:0] step_lim;
  logic signed [AW:0] step;
  logic signed [AW:0] pos_sum;
  logic signed [RW:0] rate_ext;
  logic signed [RW:0] rate_lim;
  logic signed [RW-1:0] rate_clamped;

  // angle step from the last emitted angle, clamped symmetric
  always_comb begin
    diff     = $signed({pos_i[AW-1], pos_i}) - $signed({last_i[AW-1], last_i});
    step_lim = $signed({{(AW+1-LW){1'b0}}, max_step_i});
    if (diff > step_lim) begin
      step = step_lim;
    end else if (diff < -step_lim) begin
      step = -step_lim;
    end else begin
      step = diff;
    end
    pos_sum = $signed({last_i[AW-1], last_i}) + step;
  end

  // rate magnitude clamp
  always_comb begin
    rate_ext = $signed({rate_i[RW-1], rate_i});
    rate_lim = $signed({{(RW+1-LW){1'b0}}, max_rate_i});
    if (rate_ext > rate_lim) begin
      rate_clamped = rate_lim[RW-1:0];
    end else if (rate_ext < -rate_lim) begin
      rate_clamped = RW'(-rate_lim);
    end else begin
      rate_clamped = rate_i;
    end
  end

  assign pos_o  = clamp_en_i ? pos_sum[AW-1:0] : pos_i;
  assign rate_o = clamp_en_i ? rate_clamped : rate_i;

endmodule

// ===== sv/tdjsl_leg_state.sv =====
// per-leg arming state, touchdown countdown and last emitted angles
// depends on tdjsl_pkg
module tdjsl_leg_state #(
  parameter int NUM_LEGS       = 4,
  parameter int JOINTS_PER_LEG = 3
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               fire_i,
  input  logic [tdjsl_pkg::LEG_W-1:0]                        leg_i,
  input  logic                                               on_i,
  input  logic                                               contact_i,
  input  logic [tdjsl_pkg::SLEW_W-1:0]                       slew_frames_i,
  input  logic [JOINTS_PER_LEG-1:0][tdjsl_pkg::ANGLE_W-1:0]  new_angle_i,
  output logic [JOINTS_PER_LEG-1:0][tdjsl_pkg::ANGLE_W-1:0]  last_angle_o,
  output tdjsl_pkg::ctl_t                                    ctl_o
);

  localparam int IDX_W = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
  localparam int SW    = tdjsl_pkg::SLEW_W;

  logic [JOINTS_PER_LEG-1:0][tdjsl_pkg::ANGLE_W-1:0] last_q [NUM_LEGS];
  logic [NUM_LEGS-1:0] prev_contact_q;
  logic [NUM_LEGS-1:0] primed_q;
  logic [SW-1:0]       count_q [NUM_LEGS];

  logic [IDX_W-1:0] idx;
  logic             leg_ok;
  logic             armed;
  logic [SW-1:0]    count_eff;
  logic [SW-1:0]    count_next;

  // leg decode
  assign idx    = IDX_W'(leg_i);
  assign leg_ok = (32'(leg_i) < NUM_LEGS);
  assign armed  = on_i && primed_q[idx];

  // touchdown edge reloads the countdown
  always_comb begin
    count_eff = (!prev_contact_q[idx] && contact_i) ? slew_frames_i : count_q[idx];
    ctl_o.leg_ok = leg_ok;
    ctl_o.limit  = leg_ok && armed && contact_i && (count_eff != '0);
    if (ctl_o.limit) begin
      count_next = count_eff - SW'(1);
    end else if (!contact_i) begin
      count_next = '0;
    end else begin
      count_next = count_eff;
    end
  end

  assign last_angle_o = last_q[idx];

  // state update on each accepted beat of a valid leg
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_contact_q <= '0;
      primed_q       <= '0;
      for (int l = 0; l < NUM_LEGS; l++) begin
        count_q[l] <= '0;
        last_q[l]  <= '0;
      end
    end else if (fire_i && leg_ok) begin
      last_q[idx] <= new_angle_i;
      if (!on_i) begin
        primed_q[idx] <= 1'b0;
        count_q[idx]  <= '0;
      end else if (!primed_q[idx]) begin
        primed_q[idx]       <= 1'b1;
        prev_contact_q[idx] <= contact_i;
      end else begin
        count_q[idx]        <= count_next;
        prev_contact_q[idx] <= contact_i;
      end
    end
  end

endmodule

// ===== sv/tdjsl_merge.sv =====
// merges lane results into one result beat, two-entry output buffer
// depends on tdjsl_pkg
module tdjsl_merge (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    fire_i,
  input  logic [tdjsl_pkg::LEG_W-1:0]                             leg_i,
  input  logic                                                    limit_i,
  input  logic [tdjsl_pkg::JOINTS_MAX-1:0][tdjsl_pkg::ANGLE_W-1:0] pos_i,
  input  logic [tdjsl_pkg::JOINTS_MAX-1:0][tdjsl_pkg::RATE_W-1:0]  rate_i,
  input  logic                                                    out_stall_i,
  output logic                                                    out_valid_o,
  output tdjsl_pkg::out_item_t                                    out_data_o,
  output logic                                                    full_o
);

  tdjsl_pkg::out_item_t merged;
  tdjsl_pkg::out_item_t out_q;
  tdjsl_pkg::out_item_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;
  logic out_fire;
  logic load_from_skid;
  logic load_new_out;
  logic load_new_skid;

  // gather lane outputs into one beat
  always_comb begin
    merged.leg_out    = leg_i;
    merged.pos_out_0  = pos_i[0];
    merged.pos_out_1  = pos_i[1];
    merged.pos_out_2  = pos_i[2];
    merged.rate_out_0 = rate_i[0];
    merged.rate_out_1 = rate_i[1];
    merged.rate_out_2 = rate_i[2];
    merged.limiting   = limit_i;
  end

  // buffer steering; a new beat arrives only when the skid entry is free
  assign out_fire       = out_valid_q && !out_stall_i;
  assign load_from_skid = skid_valid_q && out_fire;
  assign load_new_out   = fire_i && !skid_valid_q && (!out_valid_q || out_fire);
  assign load_new_skid  = fire_i && !skid_valid_q && out_valid_q && !out_fire;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (load_from_skid) begin
        skid_valid_q <= 1'b0;
      end else if (load_new_skid) begin
        skid_valid_q <= 1'b1;
      end
      if (load_from_skid || load_new_out) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_from_skid) begin
      out_q <= skid_q;
    end else if (load_new_out) begin
      out_q <= merged;
    end
    if (load_new_skid) begin
      skid_q <= merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full_o      = skid_valid_q;

endmodule

// ===== sv/touchdown_joint_slew_limiter.sv =====
// top level of the touchdown joint slew limiter: apb registers, leg state,
// joint lanes and output merge; depends on tdjsl_pkg, tdjsl_lane,
// tdjsl_leg_state, tdjsl_merge and touchdown_joint_slew_limiter_macros.svh
//
//   port group   direction  handshake                 payload
//   in           in         in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out          out        out_valid_o / out_stall_i out_data_o (out_item_t)
//   apb          in/out     psel, penable, pready     paddr, pwdata, prdata
//
// one frame per cycle unless in_stall_o is high; results are registered.
// the per-leg state is read and written in the accepting cycle, so frames of
// the same leg may follow each other without a gap.
// reset restores register defaults and clears all leg state at once.
// in_stall_o rises only when both output buffer entries are occupied.
`include "touchdown_joint_slew_limiter_macros.svh"

module touchdown_joint_slew_limiter #(
  parameter int NUM_LEGS       = 4,
  parameter int JOINTS_PER_LEG = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  tdjsl_pkg::in_item_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tdjsl_pkg::out_item_t                 out_data_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tdjsl_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tdjsl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tdjsl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  localparam int AW = tdjsl_pkg::ANGLE_W;
  localparam int RW = tdjsl_pkg::RATE_W;
  localparam int JM = tdjsl_pkg::JOINTS_MAX;
  localparam int DW = tdjsl_pkg::APB_DATA_W;

  logic [tdjsl_pkg::LIMIT_W-1:0] max_step_q;
  logic [tdjsl_pkg::LIMIT_W-1:0] max_rate_q;
  logic [tdjsl_pkg::SLEW_W-1:0]  slew_frames_q;
  logic [tdjsl_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;
  logic in_fire;
  logic full;

  logic [JM-1:0][AW-1:0] pos_in;
  logic [JM-1:0][RW-1:0] rate_in;
  logic [JM-1:0][AW-1:0] lane_pos;
  logic [JM-1:0][RW-1:0] lane_rate;
  logic [JOINTS_PER_LEG-1:0][AW-1:0] last_angle;
  tdjsl_pkg::ctl_t ctl;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[tdjsl_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q    <= tdjsl_pkg::MAX_STEP_RST;
      max_rate_q    <= tdjsl_pkg::MAX_RATE_RST;
      slew_frames_q <= tdjsl_pkg::SLEW_FRAMES_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        tdjsl_pkg::REG_MAX_STEP:    max_step_q    <= pwdata[tdjsl_pkg::LIMIT_W-1:0];
        tdjsl_pkg::REG_MAX_RATE:    max_rate_q    <= pwdata[tdjsl_pkg::LIMIT_W-1:0];
        tdjsl_pkg::REG_SLEW_FRAMES: slew_frames_q <= pwdata[tdjsl_pkg::SLEW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tdjsl_pkg::REG_MAX_STEP:    prdata = DW'(max_step_q);
      tdjsl_pkg::REG_MAX_RATE:    prdata = DW'(max_rate_q);
      tdjsl_pkg::REG_SLEW_FRAMES: prdata = DW'(slew_frames_q);
      default:                    prdata = '0;
    endcase
  end

  // input beat
  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign pos_in[0]  = in_data_i.pos_in_0;
  assign pos_in[1]  = in_data_i.pos_in_1;
  assign pos_in[2]  = in_data_i.pos_in_2;
  assign rate_in[0] = in_data_i.rate_in_0;
  assign rate_in[1] = in_data_i.rate_in_1;
  assign rate_in[2] = in_data_i.rate_in_2;

  // per-leg state
  tdjsl_leg_state #(
    .NUM_LEGS       (NUM_LEGS),
    .JOINTS_PER_LEG (JOINTS_PER_LEG)
  ) u_leg_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .leg_i         (in_data_i.leg),
    .on_i          (in_data_i.limiter_on),
    .contact_i     (in_data_i.contact),
    .slew_frames_i (slew_frames_q),
    .new_angle_i   (lane_pos[JOINTS_PER_LEG-1:0]),
    .last_angle_o  (last_angle),
    .ctl_o         (ctl)
  );

  // joint lanes; missing joints read as zero
  for (genvar j = 0; j < JM; j++) begin : g_lane
    if (j < JOINTS_PER_LEG) begin : g_used
      tdjsl_lane u_lane (
        .clamp_en_i (ctl.limit),
        .pos_i      (pos_in[j]),
        .rate_i     (rate_in[j]),
        .last_i     (last_angle[j]),
        .max_step_i (max_step_q),
        .max_rate_i (max_rate_q),
        .pos_o      (lane_pos[j]),
        .rate_o     (lane_rate[j])
      );
    end else begin : g_unused
      assign lane_pos[j]  = '0;
      assign lane_rate[j] = '0;
    end
  end

  // merge and output buffer
  tdjsl_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .leg_i       (in_data_i.leg),
    .limit_i     (ctl.limit),
    .pos_i       (lane_pos),
    .rate_i      (lane_rate),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .full_o      (full)
  );

  // checks
  `TDJSL_ASSERT_SAME(a_full_has_head, in_stall_o, out_valid_o)
  `TDJSL_ASSERT_NEXT(a_fill_on_stall, in_fire && out_valid_o && out_stall_i, in_stall_o)
  `TDJSL_ASSERT_SAME(a_no_limit_off, in_fire && (!in_data_i.limiter_on || !ctl.leg_ok), !ctl.limit)
  `TDJSL_ASSERT_SAME(a_rate_bound, out_valid_o && out_data_o.limiting && !$past(cfg_wr), ($signed(out_data_o.rate_out_0) <= $signed({1'b0, max_rate_q})) && ($signed(out_data_o.rate_out_0) >= -$signed({1'b0, max_rate_q})))

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for touchdown_joint_slew_limiter: directed and random leg
// frames with random gaps and output stalls, apb register sweeps, per-field compare
// depends on tdjsl_pkg and the rtl of touchdown_joint_slew_limiter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tdjsl_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tdjsl_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tdjsl_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [tdjsl_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [tdjsl_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  touchdown_joint_slew_limiter dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  // limiter model state and register copy
  logic signed [tdjsl_pkg::ANGLE_W-1:0] joint_last [4][3];
  bit leg_contact [4];
  bit leg_armed [4];
  logic [tdjsl_pkg::SLEW_W-1:0] slew_left [4];
  logic [tdjsl_pkg::LIMIT_W-1:0] step_lim = tdjsl_pkg::MAX_STEP_RST;
  logic [tdjsl_pkg::LIMIT_W-1:0] rate_lim = tdjsl_pkg::MAX_RATE_RST;
  logic [tdjsl_pkg::SLEW_W-1:0] slew_len = tdjsl_pkg::SLEW_FRAMES_RST;

  // commands still owed by the block
  tdjsl_pkg::out_item_t pending_cmds [$];
  int mismatch_count = 0;
  bit steady_traffic = 1'b0;

  // random frame generator state, one gait per leg
  bit gait_contact [4];
  int gait_pos [4][3];

  initial begin
    for (int l = 0; l < 4; l++) begin
      leg_contact[l] = 1'b0;
      leg_armed[l] = 1'b0;
      slew_left[l] = '0;
      gait_contact[l] = 1'b0;
      for (int j = 0; j < 3; j++) begin
        joint_last[l][j] = '0;
        gait_pos[l][j] = 0;
      end
    end
  end

  function automatic int clamp_sym(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // expected command for one frame; updates the leg state
  function automatic tdjsl_pkg::out_item_t predict_command(tdjsl_pkg::in_item_t f);
    int pos_w [3];
    int rate_w [3];
    int pos_o [3];
    int rate_o [3];
    int l;
    bit lim;
    tdjsl_pkg::out_item_t r;
    l = f.leg;
    lim = 1'b0;
    pos_w[0] = $signed(f.pos_in_0);
    pos_w[1] = $signed(f.pos_in_1);
    pos_w[2] = $signed(f.pos_in_2);
    rate_w[0] = $signed(f.rate_in_0);
    rate_w[1] = $signed(f.rate_in_1);
    rate_w[2] = $signed(f.rate_in_2);
    pos_o = pos_w;
    rate_o = rate_w;
    if (!f.limiter_on) begin
      // disabled: pass through and disarm, contact history kept
      leg_armed[l] = 1'b0;
      slew_left[l] = '0;
      for (int j = 0; j < 3; j++) joint_last[l][j] = 16'(pos_w[j]);
    end else if (!leg_armed[l]) begin
      // priming frame
      leg_contact[l] = f.contact;
      leg_armed[l] = 1'b1;
      for (int j = 0; j < 3; j++) joint_last[l][j] = 16'(pos_w[j]);
    end else begin
      if (!leg_contact[l] && f.contact) slew_left[l] = slew_len;
      if (f.contact && slew_left[l] != 0) begin
        lim = 1'b1;
        for (int j = 0; j < 3; j++) begin
          pos_o[j] = int'(joint_last[l][j])
                     + clamp_sym(pos_w[j] - int'(joint_last[l][j]), int'(step_lim));
          rate_o[j] = clamp_sym(rate_w[j], int'(rate_lim));
        end
        slew_left[l] = slew_left[l] - 1'b1;
      end else if (!f.contact) begin
        slew_left[l] = '0;
      end
      for (int j = 0; j < 3; j++) joint_last[l][j] = 16'(pos_o[j]);
      leg_contact[l] = f.contact;
    end
    r.leg_out = f.leg;
    r.pos_out_0 = 16'(pos_o[0]);
    r.pos_out_1 = 16'(pos_o[1]);
    r.pos_out_2 = 16'(pos_o[2]);
    r.rate_out_0 = 16'(rate_o[0]);
    r.rate_out_1 = 16'(rate_o[1]);
    r.rate_out_2 = 16'(rate_o[2]);
    r.limiting = lim;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s got %h want %h", $time, what, got, want);
  endtask

  // output beat checker
  always @(posedge clk_i) begin
    tdjsl_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("beat with nothing expected", 32'(out_data_o), '0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_data_o.leg_out !== want.leg_out)
          report_mismatch("leg_out", 32'(out_data_o.leg_out), 32'(want.leg_out));
        if (out_data_o.pos_out_0 !== want.pos_out_0)
          report_mismatch("pos_out_0", 32'(out_data_o.pos_out_0), 32'(want.pos_out_0));
        if (out_data_o.pos_out_1 !== want.pos_out_1)
          report_mismatch("pos_out_1", 32'(out_data_o.pos_out_1), 32'(want.pos_out_1));
        if (out_data_o.pos_out_2 !== want.pos_out_2)
          report_mismatch("pos_out_2", 32'(out_data_o.pos_out_2), 32'(want.pos_out_2));
        if (out_data_o.rate_out_0 !== want.rate_out_0)
          report_mismatch("rate_out_0", 32'(out_data_o.rate_out_0), 32'(want.rate_out_0));
        if (out_data_o.rate_out_1 !== want.rate_out_1)
          report_mismatch("rate_out_1", 32'(out_data_o.rate_out_1), 32'(want.rate_out_1));
        if (out_data_o.rate_out_2 !== want.rate_out_2)
          report_mismatch("rate_out_2", 32'(out_data_o.rate_out_2), 32'(want.rate_out_2));
        if (out_data_o.limiting !== want.limiting)
          report_mismatch("limiting", 32'(out_data_o.limiting), 32'(want.limiting));
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // output stall generator
  initial begin
    int run;
    int len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      run = 1 + (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6));
      repeat (run) @(posedge clk_i);
      len = steady_traffic ? 0 : pick_gap();
      if (len > 0) begin
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // send one frame beat and record its expected command on acceptance
  task automatic send_frame(input tdjsl_pkg::in_item_t f);
    int gap;
    gap = steady_traffic ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= f;
    do @(posedge clk_i); while (in_stall_o);
    pending_cmds.push_back(predict_command(f));
  endtask

  // stop sending and wait for every owed command
  task automatic drain_commands();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [tdjsl_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tdjsl_pkg::REG_MAX_STEP: step_lim = value[tdjsl_pkg::LIMIT_W-1:0];
      tdjsl_pkg::REG_MAX_RATE: rate_lim = value[tdjsl_pkg::LIMIT_W-1:0];
      tdjsl_pkg::REG_SLEW_FRAMES: slew_len = value[tdjsl_pkg::SLEW_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apb_check(input logic [tdjsl_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic tdjsl_pkg::in_item_t frame_of(int leg, bit on, bit contact, int p0,
                                                   int p1, int p2, int r0, int r1, int r2);
    tdjsl_pkg::in_item_t f;
    f.leg = 2'(leg);
    f.limiter_on = on;
    f.contact = contact;
    f.pos_in_0 = 16'(p0);
    f.pos_in_1 = 16'(p1);
    f.pos_in_2 = 16'(p2);
    f.rate_in_0 = 16'(r0);
    f.rate_in_1 = 16'(r1);
    f.rate_in_2 = 16'(r2);
    return f;
  endfunction

  function automatic int full_range();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // gait-like frame: mostly enabled, contact toggling, angles drifting
  function automatic tdjsl_pkg::in_item_t next_gait_frame();
    int leg;
    int sel;
    int p [3];
    int r [3];
    bit on;
    if ($urandom_range(0, 9) == 0)
      return frame_of($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                      full_range(), full_range(), full_range(),
                      full_range(), full_range(), full_range());
    leg = $urandom_range(0, 3);
    on = ($urandom_range(0, 15) != 0);
    if ($urandom_range(0, 3) == 0) gait_contact[leg] = !gait_contact[leg];
    for (int j = 0; j < 3; j++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) p[j] = gait_pos[leg][j] + int'($urandom_range(0, 400)) - 200;
      else if (sel < 8) p[j] = gait_pos[leg][j] + int'($urandom_range(0, 8000)) - 4000;
      else p[j] = full_range();
      if (p[j] > 32767) p[j] = 32767;
      if (p[j] < -32768) p[j] = -32768;
      gait_pos[leg][j] = p[j];
      if ($urandom_range(0, 1) == 0)
        r[j] = int'($urandom_range(0, 2 * int'(rate_lim) + 2)) - int'(rate_lim) - 1;
      else
        r[j] = full_range();
    end
    return frame_of(leg, on, gait_contact[leg], p[0], p[1], p[2], r[0], r[1], r[2]);
  endfunction

  task automatic test_register_defaults();
    apb_check(tdjsl_pkg::REG_MAX_STEP, 32'(tdjsl_pkg::MAX_STEP_RST));
    apb_check(tdjsl_pkg::REG_MAX_RATE, 32'(tdjsl_pkg::MAX_RATE_RST));
    apb_check(tdjsl_pkg::REG_SLEW_FRAMES, 32'(tdjsl_pkg::SLEW_FRAMES_RST));
  endtask

  task automatic test_directed_frames();
    steady_traffic = 1'b1;
    // disabled frames pass through at the field extremes
    send_frame(frame_of(0, 0, 1, 32767, -32768, 0, 32767, -32768, -1));
    send_frame(frame_of(0, 0, 0, -32768, 32767, -1, -32768, 32767, 0));
    // priming out of contact, then touchdown with full-scale requests
    send_frame(frame_of(0, 1, 0, 0, 0, 0, 0, 0, 0));
    send_frame(frame_of(0, 1, 1, 32767, -32768, 100, 32767, -32768, 100));
    send_frame(frame_of(0, 1, 1, 32767, -32768, -100, -5000, 5000, -4096));
    // lift-off clears the countdown, second touchdown reloads it
    send_frame(frame_of(0, 1, 0, 2000, -2000, 50, 300, -300, 7));
    send_frame(frame_of(0, 1, 1, -2000, 2000, 50, 0, 1, -1));
    // priming in contact gives no edge
    send_frame(frame_of(1, 1, 1, 100, 200, 300, 9000, -9000, 0));
    send_frame(frame_of(1, 1, 1, 5000, 5000, 5000, 9000, -9000, 0));
    send_frame(frame_of(1, 1, 0, 5000, 5000, 5000, 0, 0, 0));
    send_frame(frame_of(1, 1, 1, -5000, -5000, -5000, 4097, -4097, 4096));
    // disabling mid-slew disarms, next enabled frame primes again
    send_frame(frame_of(1, 0, 1, 1000, 1000, 1000, 0, 0, 0));
    send_frame(frame_of(1, 1, 1, 1000, 1000, 1000, 8000, 8000, 8000));
    send_frame(frame_of(1, 1, 1, 9000, -9000, 9000, 8000, 8000, 8000));
    // countdown runs out after the programmed number of frames
    send_frame(frame_of(3, 1, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 10; k++)
      send_frame(frame_of(3, 1, 1, 32767, -32768, 16384, 20000, -20000, 0));
    drain_commands();
    steady_traffic = 1'b0;
  endtask

  // program the limits, read them back, then run gait frames
  task automatic run_gait_phase(input int step, input int rate, input int slew,
                                input int frames, input bit steady);
    drain_commands();
    apb_write(tdjsl_pkg::REG_MAX_STEP, 32'(step));
    apb_write(tdjsl_pkg::REG_MAX_RATE, 32'(rate));
    apb_write(tdjsl_pkg::REG_SLEW_FRAMES, 32'(slew));
    apb_check(tdjsl_pkg::REG_MAX_STEP, 32'(step));
    apb_check(tdjsl_pkg::REG_MAX_RATE, 32'(rate));
    apb_check(tdjsl_pkg::REG_SLEW_FRAMES, 32'(slew));
    steady_traffic = steady;
    for (int n = 0; n < frames; n++) begin
      // hold off now and then until every command is back
      if (n == frames / 2 || $urandom_range(0, 99) == 0) drain_commands();
      send_frame(next_gait_frame());
    end
    steady_traffic = 1'b0;
  endtask

  task automatic test_limit_sweep();
    run_gait_phase(164, 4096, 8, 170, 1'b0);
    run_gait_phase(0, 0, 255, 170, 1'b0);
    run_gait_phase(32767, 32767, 1, 170, 1'b1);
    run_gait_phase($urandom_range(0, 32767), $urandom_range(0, 32767), 0, 170, 1'b0);
    run_gait_phase($urandom_range(1, 600), $urandom_range(0, 32767),
                   $urandom_range(1, 12), 170, 1'b0);
    run_gait_phase($urandom_range(1, 3000), $urandom_range(1, 8000),
                   $urandom_range(2, 40), 170, 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_directed_frames();
    test_limit_sweep();
    drain_commands();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(8_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tdjsl_pkg.sv
sv/tdjsl_lane.sv
sv/tdjsl_leg_state.sv
sv/tdjsl_merge.sv
sv/touchdown_joint_slew_limiter.sv
verif/testbench.sv
